// ===== hw/rtl/etbc_pkg.sv =====
// Shared types and constants of the energy-triggered burst capture block.
package etbc_pkg;

    localparam int BLOCK_SAMPLES = 2048;
    localparam int POS_W         = $clog2(BLOCK_SAMPLES);

    localparam int SAMPLE_W = 16;
    localparam int SQ_W     = 2 * SAMPLE_W - 1;
    localparam int SUM_W    = 42;
    localparam int LEN_W    = 21;

    localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(111360);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SUM_W;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH    = CFG_IDX_W'(1);

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // One replayed sample handed from the front to the output queue.
    typedef struct packed {
        logic                       valid;
        logic                       negate;
        logic                       last;
        logic signed [SAMPLE_W-1:0] sample;
    } t_item;

    // One stored queue entry.
    typedef struct packed {
        logic                       negate;
        logic                       last;
        logic signed [SAMPLE_W-1:0] sample;
    } t_entry;

endpackage

// ===== hw/rtl/etbc_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
module etbc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the contents held before a write in the same cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/etbc_front.sv =====
// Front end: sample intake, block energy, trigger control and delay memory.
module etbc_front (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic signed [etbc_pkg::SAMPLE_W-1:0]   i_sample_in,
    input  logic                                   i_cfg_we,
    input  logic        [etbc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic        [etbc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic        [etbc_pkg::Q_CNT_W-1:0]    i_q_count,
    output etbc_pkg::t_item                        o_item
);

    localparam int SW = etbc_pkg::SAMPLE_W;
    localparam int PW = etbc_pkg::POS_W;
    localparam int LW = etbc_pkg::LEN_W;
    localparam int UW = etbc_pkg::SUM_W;
    localparam int QW = etbc_pkg::Q_CNT_W;
    localparam logic [PW-1:0] POS_END = PW'(etbc_pkg::BLOCK_SAMPLES - 1);

    // Configuration
    logic [UW-1:0] r_thr;
    logic [LW-1:0] r_len;

    // Control state
    logic [PW-1:0] r_pos,    n_pos;
    logic          r_replay, n_replay;
    logic          r_active, n_active;
    logic [LW-1:0] r_count,  n_count;
    logic [UW-1:0] r_sum,    n_sum;

    // Energy pipeline
    logic [etbc_pkg::SQ_W-1:0] r_sq;
    logic                      r_sq_valid;
    logic                      r_sq_end;

    // Replay read in flight
    logic          r_rd_valid;
    logic          r_rd_neg;
    logic          r_rd_last;
    logic [SW-1:0] w_rdata;

    logic                 w_accept;
    logic [QW:0]          w_used;
    logic signed [2*SW-1:0] w_prod;
    logic [UW:0]          w_sum_ext;
    logic [UW-1:0]        w_sum_sat;
    logic                 w_last;

    // Hold off intake while a block's energy test resolves or the queue lacks room
    assign w_used   = {1'b0, i_q_count} + {{QW{1'b0}}, r_rd_valid};
    assign full     = (r_sq_valid && r_sq_end) || (w_used >= (QW+1)'(etbc_pkg::Q_DEPTH));
    assign w_accept = push && !full;

    assign w_prod    = i_sample_in * i_sample_in;
    assign w_sum_ext = {1'b0, r_sum} + {{(UW+1-etbc_pkg::SQ_W){1'b0}}, r_sq};
    assign w_sum_sat = w_sum_ext[UW] ? etbc_pkg::SUM_MAX : w_sum_ext[UW-1:0];
    assign w_last    = ({1'b0, r_count} + {{LW{1'b0}}, 1'b1}) >= {1'b0, r_len};

    // Advance position, replay count, energy sum and trigger state
    always_comb begin
        n_pos    = r_pos;
        n_replay = r_replay;
        n_active = r_active;
        n_count  = r_count;
        n_sum    = r_sum;
        if (w_accept) begin
            n_pos = (r_pos == POS_END) ? '0 : r_pos + PW'(1);
            if (r_replay) begin
                if (w_last) begin
                    n_replay = 1'b0;
                    n_active = 1'b0;
                    n_count  = '0;
                end else begin
                    n_count = r_count + LW'(1);
                end
            end
        end
        if (r_sq_valid) begin
            n_sum = w_sum_sat;
            if (r_sq_end) begin
                n_sum = '0;
                if (!r_active && (w_sum_sat > r_thr)) begin
                    n_active = 1'b1;
                    n_replay = 1'b1;
                    n_count  = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_replay   <= 1'b0;
            r_active   <= 1'b0;
            r_count    <= '0;
            r_sum      <= '0;
            r_sq_valid <= 1'b0;
            r_sq_end   <= 1'b0;
            r_rd_valid <= 1'b0;
            r_thr      <= '0;
            r_len      <= etbc_pkg::LEN_RESET;
        end else begin
            r_pos      <= n_pos;
            r_replay   <= n_replay;
            r_active   <= n_active;
            r_count    <= n_count;
            r_sum      <= n_sum;
            r_sq_valid <= w_accept;
            r_sq_end   <= w_accept && (r_pos == POS_END);
            r_rd_valid <= w_accept && r_replay;
            // Take register writes; unknown indexes are dropped
            if (i_cfg_we) begin
                if (i_cfg_idx == etbc_pkg::CFG_THRESHOLD) begin
                    r_thr <= i_cfg_data[UW-1:0];
                end else if (i_cfg_idx == etbc_pkg::CFG_LENGTH) begin
                    r_len <= i_cfg_data[LW-1:0];
                end
            end
        end
    end

    // Square and replay tags carry no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sq      <= w_prod[etbc_pkg::SQ_W-1:0];
            r_rd_neg  <= r_count[0];
            r_rd_last <= w_last;
        end
    end

    // Delay memory: old block is read at the slot the new sample overwrites
    etbc_ram #(
        .WIDTH (SW),
        .DEPTH (etbc_pkg::BLOCK_SAMPLES)
    ) u_block_store (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (r_pos),
        .i_wdata (i_sample_in),
        .i_raddr (r_pos),
        .o_rdata (w_rdata)
    );

    assign o_item.valid  = r_rd_valid;
    assign o_item.negate = r_rd_neg;
    assign o_item.last   = r_rd_last;
    assign o_item.sample = w_rdata;

`ifndef NO_ASSERTIONS
    a_end_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sq_valid && r_sq_end) |-> !w_accept)
        else $error("sample taken while block energy test pending");

    a_replay_in_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_replay |-> r_active)
        else $error("replay running outside a capture");

    a_read_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_valid |-> $past(w_accept && r_replay))
        else $error("replay read without a replaying transaction");
`endif

endmodule

// ===== hw/rtl/etbc_queue.sv =====
// Back end: output queue that conjugates samples on the way out.
module etbc_queue (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  etbc_pkg::t_item                      i_item,
    output logic [etbc_pkg::Q_CNT_W-1:0]         o_count,
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [etbc_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                                 o_burst_last
);

    localparam int PTW = etbc_pkg::Q_PTR_W;
    localparam int CW  = etbc_pkg::Q_CNT_W;

    etbc_pkg::t_entry r_mem [etbc_pkg::Q_DEPTH];
    logic [PTW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             w_pop;
    etbc_pkg::t_entry w_head;

    assign w_pop = pop && !empty;

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_item.valid) begin
            n_wr_ptr = (r_wr_ptr == PTW'(etbc_pkg::Q_DEPTH - 1)) ? '0 : r_wr_ptr + PTW'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTW'(etbc_pkg::Q_DEPTH - 1)) ? '0 : r_rd_ptr + PTW'(1);
        end
        if (i_item.valid && !w_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_item.valid && w_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store incoming transaction
    always_ff @(posedge i_clk) begin
        if (i_item.valid) begin
            r_mem[r_wr_ptr] <= '{negate: i_item.negate, last: i_item.last,
                                 sample: i_item.sample};
        end
    end

    // Present head; negation of the most negative value wraps
    assign w_head       = r_mem[r_rd_ptr];
    assign o_sample_out = w_head.negate ? -w_head.sample : w_head.sample;
    assign o_burst_last = w_head.last;
    assign empty        = (r_count == '0);
    assign o_count      = r_count;

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.valid |-> (r_count < CW'(etbc_pkg::Q_DEPTH)))
        else $error("output queue written while full");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(etbc_pkg::Q_DEPTH))
        else $error("output queue occupancy out of range");
`endif

endmodule

// ===== hw/rtl/energy_triggered_burst_capture.sv =====
// Energy-triggered burst capture: detects energetic sample blocks and replays a conjugated burst.
//
// Interleaved I/Q samples enter through push/full, one per clock while full is low, and are
// grouped into blocks of etbc_pkg::BLOCK_SAMPLES. After each block's final sample, full rises
// for one cycle while that block's sum of squares completes its add and compare against the
// threshold; full also stays high while the output queue lacks room.
// The energy path is a registered 16x16 square followed by a saturating 42-bit add.
// A triggered block is replayed one block late from a single-port-style delay memory
// (read before write at the same slot); a replayed sample passes through the memory's read
// register, then into the output queue. The delay memory is not cleared at reset; no
// unwritten entry is ever replayed. Configuration writes (threshold at index 0, capture
// length at index 1) belong in idle periods.
module energy_triggered_burst_capture (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic signed [etbc_pkg::SAMPLE_W-1:0]   i_sample_in,
    output logic                                   empty,
    input  logic                                   pop,
    output logic signed [etbc_pkg::SAMPLE_W-1:0]   o_sample_out,
    output logic                                   o_burst_last,
    input  logic                                   i_cfg_we,
    input  logic        [etbc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic        [etbc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    etbc_pkg::t_item                w_item;
    logic [etbc_pkg::Q_CNT_W-1:0]   w_q_count;

    // Intake, energy test and replay
    etbc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_sample_in (i_sample_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_q_count   (w_q_count),
        .o_item      (w_item)
    );

    // Output queue
    etbc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_item),
        .o_count      (w_q_count),
        .empty        (empty),
        .pop          (pop),
        .o_sample_out (o_sample_out),
        .o_burst_last (o_burst_last)
    );

endmodule
